[design/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and constants of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 32;
	localparam int PAGE_COUNT  = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int WORD_BITS   = 64;
	localparam int BIT_IDX_W   = 6;
	localparam int WORD_COUNT  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int PAGE_IDX_W  = WORD_IDX_W + BIT_IDX_W;
	localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
	localparam int END_W       = PAGE_NUM_W + 2;
	localparam int LAST_BITS   = PAGE_COUNT - (WORD_COUNT - 1) * WORD_BITS;

	// bits of the last word that lie past the table, always seen as used
	localparam logic [WORD_BITS-1:0] TAIL_USED = (LAST_BITS == WORD_BITS) ? '0 :
		~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

	typedef enum logic [1:0] {
		OP_ALLOC     = 2'd0,
		OP_FREE      = 2'd1,
		OP_MARK_FREE = 2'd2,
		OP_MARK_USED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_ALLOC,
		MODE_CLEAR,
		MODE_SET
	} mode_t;

	// decoded request handed to the sequencer
	typedef struct packed {
		mode_t                 mode;
		logic                  empty;
		logic [WORD_IDX_W-1:0] first_word;
		logic [WORD_IDX_W-1:0] last_word;
		logic [BIT_IDX_W-1:0]  first_lo;
		logic [BIT_IDX_W-1:0]  last_hi;
	} req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic              out_of_memory;
	} result_t;

endpackage

[design/bitmap_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// first-fit physical page allocator over a used/free bitmap
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one transaction carries kind, address
//   and length. kind selects allocate, free one page, mark a byte range free
//   (length rounded down to pages) or mark a range used (rounded up).
//   output channel (out_valid/out_ready): exactly one transaction per input,
//   page_address holds the allocated page, out_of_memory flags a failed
//   allocate; both are zero for the other kinds.
// timing
//   the bitmap sits in a ram of 64-bit words; the sequencer streams one word
//   a cycle through the shared word unit (read, search or mask, write back).
//   allocate stops at the first word with a free page, or after the last word;
//   a range walks every word it touches; an empty range reads no words.
//   in_ready is low while a transaction is in the sequencer.
// reset
//   every page is used after reset; per word valid flops make unwritten
//   words read as all used, so no clearing pass is needed.
// stall
//   the result sits in an output register; the sequencer accepts the next
//   transaction while it waits, and holds its own result until the output
//   register frees up.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] page_address,
	output logic              out_of_memory
);

	req_t                  req;
	seq_status_t           status;
	result_t               seq_res;
	logic                  start;
	logic                  res_ready;

	logic [PAGE_NUM_W-1:0] page_num;
	logic [END_W-1:0]      page_cnt;
	logic [END_W-1:0]      end_raw;
	logic [END_W-1:0]      end_clamp;
	logic [END_W-1:0]      end_m1;
	logic [PAGE_IDX_W-1:0] first_idx;
	logic [PAGE_IDX_W-1:0] last_idx;

	logic                  out_valid_q;
	result_t               out_q;

	// request decode: page range [page_num, end_clamp) clipped to the table; allocate spans all words
	always_comb begin
		page_num = address[ADDR_W-1:PAGE_SHIFT];
		case (op_t'(kind))
			OP_FREE:      page_cnt = END_W'(1);
			OP_MARK_FREE: page_cnt = END_W'(length[LEN_W-1:PAGE_SHIFT]);
			// round up: any byte in the last partial page counts
			OP_MARK_USED: page_cnt = END_W'(length[LEN_W-1:PAGE_SHIFT]) +
				END_W'(|length[PAGE_SHIFT-1:0]);
			default:      page_cnt = '0;
		endcase
		end_raw   = END_W'(page_num) + page_cnt;
		end_clamp = (end_raw > END_W'(PAGE_COUNT)) ? END_W'(PAGE_COUNT) : end_raw;
		end_m1    = end_clamp - END_W'(1);
		first_idx = page_num[PAGE_IDX_W-1:0];
		last_idx  = end_m1[PAGE_IDX_W-1:0];

		req = '0;
		case (op_t'(kind))
			OP_ALLOC: begin
				req.mode       = MODE_ALLOC;
				req.empty      = 1'b0;
				req.first_word = '0;
				req.last_word  = WORD_IDX_W'(WORD_COUNT - 1);
				req.first_lo   = '0;
				req.last_hi    = '1;
			end
			default: begin
				req.mode       = (op_t'(kind) == OP_MARK_USED) ? MODE_SET : MODE_CLEAR;
				req.empty      = (END_W'(page_num) >= end_clamp);
				req.first_word = first_idx[PAGE_IDX_W-1:BIT_IDX_W];
				req.last_word  = last_idx[PAGE_IDX_W-1:BIT_IDX_W];
				req.first_lo   = first_idx[BIT_IDX_W-1:0];
				req.last_hi    = last_idx[BIT_IDX_W-1:0];
			end
		endcase
	end

	assign in_ready  = !status.busy;
	assign start     = in_valid && in_ready;
	// sequencer may hand over a result when the output slot is free this cycle
	assign res_ready = !out_valid_q || out_ready;

	bpa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.res_ready(res_ready),
		.status   (status),
		.result   (seq_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (status.done && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= seq_res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign page_address  = out_q.page_address;
	assign out_of_memory = out_q.out_of_memory;

endmodule

[design/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/bpa_word_unit.sv]
// ----------------------------------------------------------------------------
// bpa_word_unit
// shared word unit: first free bit search and masked set or clear
// ----------------------------------------------------------------------------
module bpa_word_unit
	import bpa_pkg::*;
(
	input  logic [WORD_BITS-1:0] word_in,
	input  mode_t                mode,
	input  logic [BIT_IDX_W-1:0] lo,
	input  logic [BIT_IDX_W-1:0] hi,
	input  logic                 is_last,
	output logic [WORD_BITS-1:0] word_out,
	output logic                 hit,
	output logic [BIT_IDX_W-1:0] bit_idx
);

	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] mask;
	logic [BIT_IDX_W-1:0] top_bit;

	always_comb begin
		top_bit = '1;
		avail   = ~(word_in | (is_last ? TAIL_USED : '0));
		mask    = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (top_bit - hi));
		hit     = |avail;
		// lowest free bit wins
		bit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				bit_idx = BIT_IDX_W'(i);
			end
		end
		case (mode)
			MODE_ALLOC: word_out = word_in | (WORD_BITS'(1) << bit_idx);
			MODE_CLEAR: word_out = word_in & ~mask;
			MODE_SET:   word_out = word_in | mask;
			default:    word_out = word_in;
		endcase
	end

endmodule

[design/bpa_seq.sv]
// ----------------------------------------------------------------------------
// bpa_seq
// word sequencer: streams bitmap words through the word unit
// ----------------------------------------------------------------------------
module bpa_seq
	import bpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  req_t        req,
	input  logic        res_ready,
	output seq_status_t status,
	output result_t     result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	logic                  issue_q;
	logic [WORD_IDX_W-1:0] rd_addr_q;
	logic                  pend_s1;
	logic [WORD_IDX_W-1:0] addr_s1;
	logic [WORD_COUNT-1:0] word_valid_q;
	result_t               res_q;

	logic                  issue;
	logic                  consume;
	logic [WORD_BITS-1:0]  rdata;
	logic [WORD_BITS-1:0]  eff_word;
	logic [WORD_BITS-1:0]  new_word;
	logic [BIT_IDX_W-1:0]  lo;
	logic [BIT_IDX_W-1:0]  hi;
	logic                  is_last;
	logic                  hit;
	logic [BIT_IDX_W-1:0]  bit_idx;
	logic                  we;
	logic                  fin;

	always_comb begin
		issue    = (state_q == ST_SCAN) && issue_q;
		consume  = (state_q == ST_SCAN) && pend_s1;
		// a word never written reads as all used, whatever the ram holds
		eff_word = word_valid_q[addr_s1] ? rdata : '1;
		lo       = (addr_s1 == req_q.first_word) ? req_q.first_lo : '0;
		hi       = (addr_s1 == req_q.last_word) ? req_q.last_hi : '1;
		is_last  = (addr_s1 == WORD_IDX_W'(WORD_COUNT - 1));
		we       = consume && ((req_q.mode != MODE_ALLOC) || hit);
		fin      = consume && (((req_q.mode == MODE_ALLOC) && hit) ||
			(addr_s1 == req_q.last_word));
	end

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s1),
		.wdata(new_word),
		.re   (issue),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	bpa_word_unit u_unit (
		.word_in (eff_word),
		.mode    (req_q.mode),
		.lo      (lo),
		.hi      (hi),
		.is_last (is_last),
		.word_out(new_word),
		.hit     (hit),
		.bit_idx (bit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= '0;
			issue_q      <= 1'b0;
			rd_addr_q    <= '0;
			pend_s1      <= 1'b0;
			addr_s1      <= '0;
			word_valid_q <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q     <= req;
						res_q     <= '0;
						pend_s1   <= 1'b0;
						rd_addr_q <= req.first_word;
						if (req.empty) begin
							issue_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					pend_s1 <= issue;
					addr_s1 <= rd_addr_q;
					if (issue) begin
						if (rd_addr_q == req_q.last_word) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + WORD_IDX_W'(1);
						end
					end
					if (we) begin
						word_valid_q[addr_s1] <= 1'b1;
					end
					if (fin) begin
						issue_q <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= ST_DONE;
						if (req_q.mode == MODE_ALLOC) begin
							if (hit) begin
								res_q.page_address <= ADDR_W'({addr_s1, bit_idx}) << PAGE_SHIFT;
							end else begin
								res_q.out_of_memory <= 1'b1;
							end
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.done = (state_q == ST_DONE);
	assign result      = res_q;

endmodule
